// ===== rtl/mexp_pkg.sv =====
// Shared constants and types of the modular exponentiation block.
package mexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPONENT = 1'd0,
        REG_MODULUS  = 1'd1
    } t_reg_idx;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RED  = 6'b000010,
        ST_BIT  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_SQR  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    typedef struct packed {
        logic                     start;
        logic [OPERAND_WIDTH-1:0] a;
        logic [OPERAND_WIDTH-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [OPERAND_WIDTH-1:0] result;
    } t_mul_sts;

endpackage

// ===== rtl/mexp_in_if.sv =====
// Input channel carrying one base value per transfer.
interface mexp_in_if;
    logic                         valid;
    logic                         ready;
    logic [mexp_pkg::FIELD_W-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink (input valid, input base_value, output ready);
endinterface

// ===== rtl/mexp_out_if.sv =====
// Output channel carrying one power result per transfer.
interface mexp_out_if;
    logic                         valid;
    logic                         ready;
    logic [mexp_pkg::FIELD_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

// ===== rtl/mexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module mexp_mulmod (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mexp_pkg::t_mul_req                   i_req,
    input  logic [mexp_pkg::OPERAND_WIDTH:0]     i_mod,
    output mexp_pkg::t_mul_sts                   o_sts
);

    localparam int W = mexp_pkg::OPERAND_WIDTH;

    logic [W-1:0]               r_a;
    logic [W-1:0]               r_b;
    logic [W:0]                 r_m;
    logic [W-1:0]               r_acc;
    logic [mexp_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [W:0] dbl;
    logic [W:0] dbl_red;
    logic [W:0] sum;
    logic [W:0] sum_red;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= r_m) ? dbl - r_m : dbl;
        sum     = dbl_red + (r_b[W-1] ? {1'b0, r_a} : '0);
        sum_red = (sum >= r_m) ? sum - r_m : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_m   <= i_mod;
            r_acc <= '0;
            r_cnt <= mexp_pkg::CNT_W'(W - 1);
        end else if (r_busy) begin
            r_acc <= sum_red[W-1:0];
            r_b   <= {r_b[W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_sts.busy   = r_busy;
    assign o_sts.done   = r_done;
    assign o_sts.result = r_acc;

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_acc} < r_m))
        else $error("partial product not reduced");

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block.
// Each base is raised to the configured exponent modulo the configured modulus by
// right-to-left square and multiply, all through one bit-serial modular multiplier.
// An item needs one modular multiplication to reduce the base, one squaring per exponent
// bit and one more multiplication per set exponent bit. Each bit passes a decision state
// (ST_BIT) before its multiplications, and the result is loaded into the output register
// from ST_DONE once that register is free.
// A new base is taken only while the block is idle; a finished result waits in
// the output register and the next base may already be accepted. A zero modulus
// acts as 2 to the operand width, and a zero exponent yields 1.
module modular_exponentiation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mexp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mexp_in_if.sink                           i_base,
    mexp_out_if.source                        o_result
);

    localparam int W = mexp_pkg::OPERAND_WIDTH;

    logic [W-1:0]               r_exponent;
    logic [W-1:0]               r_modulus;
    mexp_pkg::t_state           r_state;
    mexp_pkg::t_state           n_state;
    logic [mexp_pkg::CNT_W-1:0] r_bit;
    logic [mexp_pkg::CNT_W-1:0] n_bit;
    logic [W-1:0]               r_base;
    logic [W-1:0]               n_base;
    logic [W-1:0]               r_acc;
    logic [W-1:0]               n_acc;
    logic [W-1:0]               r_out;
    logic [W-1:0]               n_out;
    logic                       r_out_valid;
    logic                       n_out_valid;

    mexp_pkg::t_mul_req mul_req;
    mexp_pkg::t_mul_sts mul_sts;
    logic [W:0]         mod_ext;
    logic               in_xfer;
    logic               out_free;
    logic               last_bit;

    assign mod_ext  = {r_modulus == '0, r_modulus};
    assign in_xfer  = i_base.valid && i_base.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign last_bit = (r_bit == mexp_pkg::CNT_W'(W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= W'(1);
            r_modulus  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mexp_pkg::REG_EXPONENT: r_exponent <= i_cfg_data[W-1:0];
                mexp_pkg::REG_MODULUS:  r_modulus  <= i_cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_base      = r_base;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mul_req     = '0;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = W'(1);
                    mul_req.b     = i_base.base_value[W-1:0];
                    n_acc         = W'(1);
                    n_state       = mexp_pkg::ST_RED;
                end
            end
            mexp_pkg::ST_RED: begin
                if (mul_sts.done) begin
                    n_base  = mul_sts.result;
                    n_bit   = '0;
                    n_state = mexp_pkg::ST_BIT;
                end
            end
            mexp_pkg::ST_BIT: begin
                mul_req.start = 1'b1;
                if (r_exponent[r_bit]) begin
                    mul_req.a = r_acc;
                    mul_req.b = r_base;
                    n_state   = mexp_pkg::ST_MUL;
                end else begin
                    mul_req.a = r_base;
                    mul_req.b = r_base;
                    n_state   = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_MUL: begin
                if (mul_sts.done) begin
                    n_acc         = mul_sts.result;
                    mul_req.start = 1'b1;
                    mul_req.a     = r_base;
                    mul_req.b     = r_base;
                    n_state       = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_SQR: begin
                if (mul_sts.done) begin
                    n_base = mul_sts.result;
                    if (last_bit) begin
                        n_state = mexp_pkg::ST_DONE;
                    end else begin
                        n_bit   = r_bit + 1'b1;
                        n_state = mexp_pkg::ST_BIT;
                    end
                end
            end
            mexp_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = mexp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit  <= n_bit;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_mod   (mod_ext),
        .o_sts   (mul_sts)
    );

    assign i_base.ready          = (r_state == mexp_pkg::ST_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.power_result = mexp_pkg::FIELD_W'(r_out);

    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_sts.busy)
        else $error("multiplier restarted while busy");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_sts.done |-> (r_state == mexp_pkg::ST_RED || r_state == mexp_pkg::ST_MUL
                          || r_state == mexp_pkg::ST_SQR))
        else $error("multiplier result arrived in wrong state");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == mexp_pkg::ST_DONE))
        else $error("result raised outside completion");

    a_wait_in_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::ST_MUL && !mul_sts.done) |-> mul_sts.busy)
        else $error("multiply state without active unit");

endmodule

// ===== tb/sv/mexp_checker.sv =====
// Checker for the modular exponentiation block: predicts each power result and compares.
`timescale 1ns / 100ps

module mexp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mexp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mexp_in_if                              i_base,
    mexp_out_if                             i_result,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);

    localparam logic [63:0] OPND_MASK = (64'd1 << mexp_pkg::OPERAND_WIDTH) - 64'd1;

    typedef struct packed {
        logic [mexp_pkg::FIELD_W-1:0] base;
        logic [mexp_pkg::FIELD_W-1:0] power;
    } t_power_due;

    logic [mexp_pkg::FIELD_W-1:0] exponent_copy;
    logic [mexp_pkg::FIELD_W-1:0] modulus_copy;
    t_power_due                   power_due_q[$];
    int                           fails;
    int                           checked;

    function automatic logic [63:0] fold_mod(input logic [63:0] x, input logic [63:0] m);
        if (m == 64'd0) begin
            return x & OPND_MASK;
        end
        return x % m;
    endfunction

    function automatic logic [mexp_pkg::FIELD_W-1:0] power_mod(
        input logic [mexp_pkg::FIELD_W-1:0] base,
        input logic [mexp_pkg::FIELD_W-1:0] expo,
        input logic [mexp_pkg::FIELD_W-1:0] modv);
        logic [63:0] m;
        logic [63:0] e;
        logic [63:0] b;
        logic [63:0] acc;
        m   = {32'd0, modv} & OPND_MASK;
        e   = {32'd0, expo} & OPND_MASK;
        b   = fold_mod({32'd0, base} & OPND_MASK, m);
        acc = 64'd1;
        for (int i = 0; i < mexp_pkg::OPERAND_WIDTH; i++) begin
            if (e[i]) begin
                acc = fold_mod((acc & OPND_MASK) * (b & OPND_MASK), m);
            end
            b = fold_mod((b & OPND_MASK) * (b & OPND_MASK), m);
        end
        return acc[mexp_pkg::FIELD_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_power_due head;
        if (!i_rst_n) begin
            exponent_copy <= 32'd1;
            modulus_copy  <= 32'hFFFF_FFFF;
            power_due_q.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (mexp_pkg::t_reg_idx'(i_cfg_idx))
                    mexp_pkg::REG_EXPONENT: exponent_copy <= i_cfg_data;
                    mexp_pkg::REG_MODULUS:  modulus_copy  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                checked++;
                if (power_due_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: result %h with no base outstanding",
                                 $realtime, i_result.power_result);
                    end
                end else begin
                    head = power_due_q.pop_front();
                    if (i_result.power_result !== head.power) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: base %h: power_result expected %h, got %h",
                                     $realtime, head.base, head.power,
                                     i_result.power_result);
                        end
                    end
                end
            end
            if (i_base.valid && i_base.ready) begin
                head.base   = i_base.base_value;
                head.power  = power_mod(i_base.base_value, exponent_copy, modulus_copy);
                power_due_q = {power_due_q, head};
            end
        end
        o_fail_count <= fails;
        o_pending    <= power_due_q.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: drives bases and register writes into the block and gives the verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES = 7000;
    localparam int STALL_LIMIT = 40000;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    mexp_pkg::t_reg_idx              cfg_idx;
    logic [mexp_pkg::CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int quiet_cycles;
    int bases_sent;
    int settings_used;
    int holds_done;
    bit src_idle;
    bit sink_idle;
    bit hold_req;

    mexp_in_if  base_ch ();
    mexp_out_if result_ch ();

    modular_exponentiation u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_base     (base_ch),
        .o_result   (result_ch)
    );

    mexp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_base       (base_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (base_ch.valid && base_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random hold-offs, plus one long hold when requested
    initial begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic push_base(input logic [mexp_pkg::FIELD_W-1:0] value);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            base_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        base_ch.valid      <= 1'b1;
        base_ch.base_value <= value;
        do @(posedge clk); while (!base_ch.ready);
        bases_sent++;
    endtask

    task automatic drain;
        base_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_config(input logic [31:0] expo, input logic [31:0] modv);
        cfg_we   <= 1'b1;
        cfg_idx  <= mexp_pkg::REG_EXPONENT;
        cfg_data <= expo;
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= mexp_pkg::REG_MODULUS;
        cfg_data <= modv;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [31:0] expo;
        logic [31:0] modv;
        logic [31:0] base;
        int          count;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= mexp_pkg::REG_EXPONENT;
        cfg_data           <= '0;
        base_ch.valid      <= 1'b0;
        base_ch.base_value <= '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        settings_used = 1;
        push_base(32'h0000_0000);
        push_base(32'h0000_0001);
        push_base(32'hFFFF_FFFF);
        push_base(32'hFFFF_FFFE);
        push_base(32'h8000_0000);
        push_base(32'h1234_5678);
        drain();

        // zero exponent, also with a unit modulus
        set_config(32'd0, 32'd1);
        push_base(32'h0000_0000);
        push_base(32'hFFFF_FFFF);
        drain();
        set_config(32'd0, 32'hFFFF_FFFF);
        push_base(32'h0000_0005);
        drain();

        // unit modulus with a nonzero exponent
        set_config(32'hFFFF_FFFF, 32'd1);
        push_base(32'h0000_0007);
        push_base(32'hFFFF_FFFF);
        drain();

        // zero modulus keeps the low bits of each product
        set_config(32'hFFFF_FFFF, 32'd0);
        push_base(32'h0000_0000);
        push_base(32'h0000_0001);
        push_base(32'h0000_0003);
        push_base(32'hFFFF_FFFF);
        drain();

        set_config(32'd2, 32'hFFFF_FFFF);
        push_base(32'hFFFF_FFFE);
        push_base(32'h0001_0000);
        drain();

        set_config(32'd65537, 32'hFFFF_FFFB);
        push_base(32'hFFFF_FFFA);
        push_base(32'hFFFF_FFFB);
        push_base(32'h0000_0002);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            count = 26;
            case (ph)
                0: begin
                    expo = 32'hFFFF_FFFF;
                    modv = $urandom;
                end
                1: begin
                    expo = $urandom;
                    modv = 32'd0;
                end
                2: begin
                    expo = 32'd0;
                    modv = $urandom;
                end
                3: begin
                    expo = $urandom & 32'h0303_0303;
                    modv = $urandom;
                end
                4: begin
                    expo = $urandom;
                    modv = 32'd1;
                end
                5: begin
                    expo = $urandom;
                    modv = $urandom_range(2, 255);
                end
                6: begin
                    expo = $urandom_range(0, 255);
                    modv = 32'hFFFF_FFFF;
                end
                default: begin
                    expo = $urandom;
                    modv = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom;
                end
            endcase
            src_idle  = (ph != 3) && (ph != 9);
            sink_idle = (ph != 9);
            if (ph == 9) begin
                count = 36;
            end
            set_config(expo, modv);
            if (ph == 3) begin
                hold_req = 1'b1;
            end
            repeat (count) begin
                case ($urandom_range(0, 7))
                    0: base = 32'h0000_0000;
                    1: base = 32'hFFFF_FFFF;
                    2: base = modv;
                    3: base = modv - 32'd1;
                    4: base = modv + 32'd1;
                    5: base = $urandom_range(0, 15);
                    default: base = $urandom;
                endcase
                push_base(base);
            end
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d bases over %0d register settings, %0d results checked.",
                 bases_sent, settings_used, checked);
        $display("Included zero exponent, unit and zero modulus, all-ones operands, %0d %s",
                 holds_done, "long output hold-off(s).");
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
